// ----- hdl/shk_pkg.sv -----
// shared types and constants for the streaming key hasher
// no dependencies
`timescale 1ns / 1ps

package shk_pkg;

    localparam int HASH_W        = 32;
    localparam int LENGTH_BITS   = 16;
    localparam int COUNT_W       = 3;
    localparam int TABLE_BUCKETS = 79;
    localparam int BUCKET_W      = 7;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // reciprocal for hash mod bucket count, estimate is low by at most one
    localparam int          BKT_SHIFT = $clog2(TABLE_BUCKETS) + 31;
    localparam int          QUOT_W    = 64 - BKT_SHIFT;
    localparam logic [63:0] BKT_RECIP_WIDE = (64'd1 << BKT_SHIFT) / TABLE_BUCKETS;
    localparam logic [31:0] BKT_RECIP = BKT_RECIP_WIDE[31:0];

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              mismatch;
    } shk_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } shk_qstat_t;

endpackage

// ----- hdl/shk_front.sv -----
// front end: accepts key words, runs the per-word mix and byte tally
// depends on shk_pkg
`timescale 1ns / 1ps

module shk_front
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [shk_pkg::HASH_W-1:0]              word_bytes,
    input  logic [shk_pkg::COUNT_W-1:0]             byte_count,
    input  logic                                    first,
    input  logic                                    last,
    input  logic [shk_pkg::LENGTH_BITS-1:0]         total_length,
    input  shk_pkg::shk_qstat_t                     qstat,
    output logic                                    push,
    output shk_pkg::shk_job_t                       push_data
);
    import shk_pkg::*;

    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;
    logic [LENGTH_BITS-1:0] decl_reg, decl_next;
    logic [2:0]             count_clamped;
    logic [HASH_W-1:0]      base_hash;
    logic [LENGTH_BITS-1:0] base_seen;
    logic [LENGTH_BITS:0]   seen_sum;
    logic                   accept;

    function automatic logic [HASH_W-1:0] mix_word(
        input logic [HASH_W-1:0] h,
        input logic [HASH_W-1:0] w,
        input logic [2:0]        n
    );
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        logic [HASH_W-1:0] h3;
        logic [HASH_W-1:0] t;
        h1 = h;
        h2 = h;
        h3 = h;
        t  = '0;
        mix_word = h;
        case (n)
            3'd4:
            begin
                h1 = h + {16'b0, w[15:0]};
                t  = 32'({w[31:16], 11'b0}) ^ h1;
                h2 = (h1 << 16) ^ t;
                mix_word = h2 + (h2 >> 11);
            end
            3'd3:
            begin
                h1 = h + {16'b0, w[15:0]};
                h2 = h1 ^ (h1 << 16);
                h3 = h2 ^ 32'({w[23:16], 18'b0});
                mix_word = h3 + (h3 >> 11);
            end
            3'd2:
            begin
                h1 = h + {16'b0, w[15:0]};
                h2 = h1 ^ (h1 << 11);
                mix_word = h2 + (h2 >> 17);
            end
            3'd1:
            begin
                h1 = h + {24'b0, w[7:0]};
                h2 = h1 ^ (h1 << 10);
                mix_word = h2 + (h2 >> 1);
            end
            default:
            begin
                mix_word = h;
            end
        endcase
    endfunction

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        count_clamped = (byte_count > 3'd4) ? 3'd4 : byte_count;
        base_hash     = first ? HASH_W'(total_length) : hash_reg;
        base_seen     = first ? '0 : seen_reg;
        decl_next     = first ? total_length : decl_reg;
        hash_next     = mix_word(base_hash, word_bytes, count_clamped);
        seen_sum      = {1'b0, base_seen} + (LENGTH_BITS + 1)'(count_clamped);
        seen_next     = seen_sum[LENGTH_BITS] ? '1 : seen_sum[LENGTH_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            seen_reg <= '0;
            decl_reg <= '0;
        end
        else if (accept)
        begin
            hash_reg <= hash_next;
            seen_reg <= seen_next;
            decl_reg <= decl_next;
        end
    end

    assign push               = accept && last;
    assign push_data.hash     = hash_next;
    assign push_data.mismatch = (seen_next != decl_next);

`ifndef SYNTHESIS
    a_first_restarts_tally: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first |=> seen_reg == LENGTH_BITS'($past(count_clamped)))
        else $error("tally not restarted on first word");
`endif

endmodule

// ----- hdl/shk_queue.sv -----
// short queue of finished running hashes between front and back end
// depends on shk_pkg
`timescale 1ns / 1ps

module shk_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  shk_pkg::shk_job_t   push_data,
    input  logic                pop,
    output shk_pkg::shk_job_t   pop_data,
    output shk_pkg::shk_qstat_t qstat
);
    import shk_pkg::*;

    shk_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("push into full queue");
    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg != QCNT_W'(QUEUE_DEPTH) |->
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue count out of step with pointers");
`endif

endmodule

// ----- hdl/shk_back.sv -----
// back end: avalanche, bucket selection by reciprocal multiply, output register
// depends on shk_pkg
`timescale 1ns / 1ps

module shk_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  shk_pkg::shk_qstat_t               qstat,
    input  shk_pkg::shk_job_t                 pop_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [shk_pkg::HASH_W-1:0]        hash_value,
    output logic [shk_pkg::BUCKET_W-1:0]      bucket,
    output logic                              length_mismatch
);
    import shk_pkg::*;

    logic                adv;

    logic                s1_valid_reg;
    logic [HASH_W-1:0]   s1_hash_reg, s1_hash_next;
    logic                s1_mis_reg;

    logic                s2_valid_reg;
    logic [HASH_W-1:0]   s2_hash_reg, s2_hash_next;
    logic                s2_mis_reg;

    logic                s3_valid_reg;
    logic [HASH_W-1:0]   s3_hash_reg;
    logic [QUOT_W-1:0]   s3_quot_reg, s3_quot_next;
    logic                s3_mis_reg;
    logic [63:0]         prod_wide;

    logic                s4_valid_reg;
    logic [HASH_W-1:0]   s4_hash_reg;
    logic [HASH_W-1:0]   s4_prod_reg, s4_prod_next;
    logic                s4_mis_reg;

    logic                out_valid_reg;
    logic [HASH_W-1:0]   out_hash_reg;
    logic [BUCKET_W-1:0] out_bucket_reg, out_bucket_next;
    logic                out_mis_reg;
    logic [HASH_W-1:0]   rem_diff;
    logic [HASH_W-1:0]   rem_fixed;

    logic [HASH_W-1:0]   a1, a2, a3, a4, a5;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !qstat.empty;

    // avalanche, first three steps
    always_comb
    begin
        a1           = pop_data.hash ^ (pop_data.hash << 3);
        a2           = a1 + (a1 >> 5);
        s1_hash_next = a2 ^ (a2 << 4);
    end

    // avalanche, last three steps
    always_comb
    begin
        a3           = s1_hash_reg + (s1_hash_reg >> 17);
        a4           = a3 ^ (a3 << 25);
        a5           = a4;
        s2_hash_next = a5 + (a5 >> 6);
    end

    assign prod_wide    = 64'(s2_hash_reg) * 64'(BKT_RECIP);
    assign s3_quot_next = prod_wide[63:BKT_SHIFT];
    assign s4_prod_next = HASH_W'(HASH_W'(s3_quot_reg) * HASH_W'(TABLE_BUCKETS));

    always_comb
    begin
        rem_diff  = s4_hash_reg - s4_prod_reg;
        rem_fixed = (rem_diff >= HASH_W'(TABLE_BUCKETS))
                    ? rem_diff - HASH_W'(TABLE_BUCKETS) : rem_diff;
        out_bucket_next = rem_fixed[BUCKET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hash_reg    <= s1_hash_next;
            s1_mis_reg     <= pop_data.mismatch;
            s2_hash_reg    <= s2_hash_next;
            s2_mis_reg     <= s1_mis_reg;
            s3_hash_reg    <= s2_hash_reg;
            s3_quot_reg    <= s3_quot_next;
            s3_mis_reg     <= s2_mis_reg;
            s4_hash_reg    <= s3_hash_reg;
            s4_prod_reg    <= s4_prod_next;
            s4_mis_reg     <= s3_mis_reg;
            out_hash_reg   <= s4_hash_reg;
            out_bucket_reg <= out_bucket_next;
            out_mis_reg    <= s4_mis_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hash_value      = out_hash_reg;
    assign bucket          = out_bucket_reg;
    assign length_mismatch = out_mis_reg;

`ifndef SYNTHESIS
    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_valid_reg))
        else $error("result without a job in the last stage");
`endif

endmodule

// ----- hdl/superfasthash_key_hasher.sv -----
// top level of the streaming key hasher: front end, job queue, back end
// depends on shk_pkg, shk_front, shk_queue, shk_back
`timescale 1ns / 1ps

// usage
// - slave channel carries one key word per transaction, first byte in bits 7:0;
//   tuser marks the first word of a key, tlast the final word
// - the first word seeds the hash with the declared length; a final word of
//   one to three bytes takes the tail rule
// - master channel gives one transaction per key: hash, bucket (hash mod 79)
//   and a length mismatch flag in tuser
// - one word per cycle is taken while the queue is not full; the per-word mix
//   of the front end, looping through the running hash register, sets this rate
// - a finished key passes through the queue, stages s1 to s4 and the output register
// - a four-entry queue sits between the mix and the avalanche/bucket pipeline;
//   when the receiver stalls, the pipeline holds and the queue fills with
//   finished keys; once the queue is full s_axis_tready drops and every word
//   waits until an entry frees
// - reset clears the running hash, the byte tally, the declared length and
//   every valid flag; the block is ready right after reset
module superfasthash_key_hasher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // word_bytes[31:0], byte_count[34:32], total_length[50:35], zero pad
    input  logic [shk_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    // first
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hash_value[31:0], bucket[38:32], zero pad
    output logic [shk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // length_mismatch
    output logic                               m_axis_tuser
);
    import shk_pkg::*;

    shk_qstat_t          qstat;
    shk_job_t            push_data;
    shk_job_t            pop_data;
    logic                push;
    logic                pop;
    logic [HASH_W-1:0]   hash_value;
    logic [BUCKET_W-1:0] bucket;

    shk_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .word_bytes   (s_axis_tdata[31:0]),
        .byte_count   (s_axis_tdata[34:32]),
        .first        (s_axis_tuser),
        .last         (s_axis_tlast),
        .total_length (s_axis_tdata[50:35]),
        .qstat        (qstat),
        .push         (push),
        .push_data    (push_data)
    );

    shk_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    shk_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .qstat           (qstat),
        .pop_data        (pop_data),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .hash_value      (hash_value),
        .bucket          (bucket),
        .length_mismatch (m_axis_tuser)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - HASH_W - BUCKET_W)'(0), bucket, hash_value};

endmodule
